// ===== hdl/hazc_pkg.sv =====
// ---------------------------------------------------------------------------
// hazc_pkg: shared types and tables of the H/alpha/A zone classifier
// Thresholds on the byte codes, palette tables, register indexes and the
// structs passed between the classifier modules.
// ---------------------------------------------------------------------------
package hazc_pkg;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 1;

  localparam logic [CfgIdxW-1:0] CfgIdxZoneSet      = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxUncontrolled = 1'd1;

  // entropy thresholds on the green code
  localparam logic [7:0] GreenHigh = 8'd230;  // H > 0.9
  localparam logic [7:0] GreenMid  = 8'd128;  // H > 0.5

  // alpha thresholds on the red code
  localparam logic [7:0] Red55   = 8'd156;
  localparam logic [7:0] Red50   = 8'd142;
  localparam logic [7:0] Red47p5 = 8'd135;
  localparam logic [7:0] Red42p5 = 8'd121;
  localparam logic [7:0] Red40   = 8'd114;

  // anisotropy threshold on the blue code
  localparam logic [7:0] BlueHalf = 8'd128;

  // base zone codes
  localparam logic [3:0] BaseUncontrolled = 4'd4;
  localparam logic [3:0] BaseUnreachable  = 4'd8;
  localparam logic [4:0] Zone16Unreachable = 5'd16;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic zone_set;
    logic uncontrolled_palette;
  } cfg_t;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pixel_t;

  typedef struct packed {
    logic [4:0] zone;
    rgb_t       color;
  } result_t;

  localparam rgb_t ColorUncontrolledBlue = '{red: 8'd67, green: 8'd109, blue: 8'd180};

  // eight-zone palette
  function automatic rgb_t pal8_lookup(input logic [3:0] base);
    rgb_t c;
    case (base)
      4'd0:    c = '{8'd176, 8'd203, 8'd10};
      4'd1:    c = '{8'd110, 8'd183, 8'd77};
      4'd2:    c = '{8'd255, 8'd236, 8'd0};
      4'd3:    c = '{8'd29,  8'd167, 8'd66};
      4'd4:    c = '{8'd185, 8'd121, 8'd82};
      4'd5:    c = '{8'd230, 8'd52,  8'd19};
      4'd6:    c = '{8'd39,  8'd104, 8'd34};
      4'd7:    c = '{8'd13,  8'd82,  8'd160};
      default: c = '{8'd0,   8'd0,   8'd0};
    endcase
    return c;
  endfunction

  // sixteen-zone palette
  function automatic rgb_t pal16_lookup(input logic [4:0] zone);
    rgb_t c;
    case (zone)
      5'd0:    c = '{8'd176, 8'd203, 8'd10};
      5'd1:    c = '{8'd136, 8'd169, 8'd24};
      5'd2:    c = '{8'd110, 8'd183, 8'd77};
      5'd3:    c = '{8'd98,  8'd196, 8'd220};
      5'd4:    c = '{8'd255, 8'd236, 8'd0};
      5'd5:    c = '{8'd209, 8'd195, 8'd0};
      5'd6:    c = '{8'd29,  8'd167, 8'd66};
      5'd7:    c = '{8'd21,  8'd132, 8'd45};
      5'd8:    c = '{8'd186, 8'd121, 8'd82};
      5'd9:    c = '{8'd67,  8'd109, 8'd180};
      5'd10:   c = '{8'd230, 8'd52,  8'd19};
      5'd11:   c = '{8'd183, 8'd35,  8'd14};
      5'd12:   c = '{8'd39,  8'd104, 8'd34};
      5'd13:   c = '{8'd22,  8'd71,  8'd21};
      5'd14:   c = '{8'd13,  8'd82,  8'd160};
      5'd15:   c = '{8'd33,  8'd58,  8'd143};
      default: c = '{8'd0,   8'd0,   8'd0};
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/hazc_if.sv =====
// ---------------------------------------------------------------------------
// hazc_if: stream channels of the zone classifier
// Pixel channel into the block and zone/color channel out of it, each a
// valid/ready handshake with its payload.
// ---------------------------------------------------------------------------
interface hazc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue,
                  output ready);
endinterface

interface hazc_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] zone;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (output valid, output zone, output out_red, output out_green,
                  output out_blue, input ready);
  modport sink   (input valid, input zone, input out_red, input out_green,
                  input out_blue, output ready);
endinterface

// ===== hdl/hazc_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// hazc_cfg_regs: configuration registers
// Write-only register file holding the zone set and palette flag.
// ---------------------------------------------------------------------------
module hazc_cfg_regs import hazc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_d, cfg_q;

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdxZoneSet:      cfg_d.zone_set             = cfg_data_i[0];
        CfgIdxUncontrolled: cfg_d.uncontrolled_palette = cfg_data_i[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/hazc_classify.sv =====
// ---------------------------------------------------------------------------
// hazc_classify: zone decision and palette lookup
// Compares the byte codes against the zone boundaries, forms the zone
// number for the selected zone set and looks up its color.
// ---------------------------------------------------------------------------
module hazc_classify import hazc_pkg::*; (
  input  pixel_t  pix_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic [3:0] base;
  logic       half;
  logic [4:0] zone16;

  // base H/alpha zone
  always_comb begin
    if (pix_i.in_green >= GreenHigh) begin
      if (pix_i.in_red >= Red55)      base = 4'd0;
      else if (pix_i.in_red >= Red40) base = 4'd1;
      else                            base = BaseUnreachable;
    end else if (pix_i.in_green >= GreenMid) begin
      if (pix_i.in_red >= Red50)      base = 4'd2;
      else if (pix_i.in_red >= Red40) base = 4'd3;
      else                            base = 4'd4;
    end else begin
      if (pix_i.in_red >= Red47p5)      base = 4'd5;
      else if (pix_i.in_red >= Red42p5) base = 4'd6;
      else                              base = 4'd7;
    end
  end

  // anisotropy split for the sixteen-zone set
  assign half   = (pix_i.in_blue >= BlueHalf);
  assign zone16 = (base == BaseUnreachable) ? Zone16Unreachable
                                            : {base, 1'b0} + {4'd0, half};

  // zone number and color
  always_comb begin
    if (cfg_i.zone_set) begin
      res_o.zone  = zone16;
      res_o.color = pal16_lookup(zone16);
    end else begin
      res_o.zone = {1'b0, base};
      if (base == BaseUncontrolled && cfg_i.uncontrolled_palette) begin
        res_o.color = ColorUncontrolledBlue;
      end else begin
        res_o.color = pal8_lookup(base);
      end
    end
  end

endmodule

// ===== hdl/h_alpha_anisotropy_zone_classifier_core.sv =====
// ---------------------------------------------------------------------------
// h_alpha_anisotropy_zone_classifier_core: H/alpha/A zone classifier
// Classifies each pixel into an H/alpha (optionally anisotropy) zone and
// returns the zone number with its palette color.
// ---------------------------------------------------------------------------
// Usage
//   in_if carries one pixel per transaction: red is the alpha code, green the
//   entropy code, blue the anisotropy code. out_if carries the zone number
//   and its palette color, one result transaction per pixel, in order.
//   The configuration port writes zone_set (index 0) and
//   uncontrolled_palette (index 1) from bit 0 of cfg_data_i; write it only
//   while no pixel is in flight.
// Pipeline and throughput
//   A pixel is captured in an input register, classified by compare logic
//   and a constant palette table, and captured in the result register,
//   which offers it on out_if. One pixel per cycle is sustained while the
//   receiver takes results, limited only by the handshake of the two
//   register stages.
// Reset and stall
//   Reset clears both stage valid flags and both configuration registers
//   (eight-zone set, brown zone six). When the receiver stalls, the result
//   holds and the input register, if empty, still takes one more pixel before
//   in_if.ready drops.
// ---------------------------------------------------------------------------
module h_alpha_anisotropy_zone_classifier_core import hazc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  hazc_in_if.sink             in_if,
  hazc_out_if.source          out_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg;
  pixel_t  pix_q;
  logic    pix_valid_q;
  result_t res;
  result_t res_q;
  logic    res_valid_q;
  logic    res_ready;
  logic    pix_ready;

  hazc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // stage handshakes
  assign res_ready = !res_valid_q || out_if.ready;
  assign pix_ready = !pix_valid_q || res_ready;
  assign in_if.ready = pix_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
    end else if (pix_ready) begin
      pix_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_ready && in_if.valid) begin
      pix_q <= '{in_red: in_if.in_red, in_green: in_if.in_green, in_blue: in_if.in_blue};
    end
  end

  hazc_classify u_classify (
    .pix_i (pix_q),
    .cfg_i (cfg),
    .res_o (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_ready) begin
      res_valid_q <= pix_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && pix_valid_q) begin
      res_q <= res;
    end
  end

  assign out_if.valid     = res_valid_q;
  assign out_if.zone      = res_q.zone;
  assign out_if.out_red   = res_q.color.red;
  assign out_if.out_green = res_q.color.green;
  assign out_if.out_blue  = res_q.color.blue;

endmodule

// ===== hdl/hazc_checker.sv =====
// ---------------------------------------------------------------------------
// hazc_checker: port-level checks of the zone classifier
// Watches the channels of the top level and is bound to it below.
// ---------------------------------------------------------------------------
module hazc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [4:0] zone_i,
  input logic [7:0] out_red_i,
  input logic [7:0] out_green_i,
  input logic [7:0] out_blue_i
);

  // stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result transaction dropped while stalled");

  // accepted pixel reaches the result register and is offered when the receiver is ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 out_ready_i |=> out_valid_i)
    else $error("result transaction missing after pixel transaction");

  // zone code range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> zone_i <= 5'd16)
    else $error("zone out of range");

  // unreachable sixteen-zone code is black
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && zone_i == 5'd16 |->
      out_red_i == 8'd0 && out_green_i == 8'd0 && out_blue_i == 8'd0)
    else $error("unreachable zone not black");

  // black only ever marks an unreachable zone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_red_i == 8'd0 && out_green_i == 8'd0 && out_blue_i == 8'd0
      |-> zone_i == 5'd8 || zone_i == 5'd16)
    else $error("black color on a reachable zone");

endmodule

bind h_alpha_anisotropy_zone_classifier_core hazc_checker u_hazc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .zone_i      (out_if.zone),
  .out_red_i   (out_if.out_red),
  .out_green_i (out_if.out_green),
  .out_blue_i  (out_if.out_blue)
);

// ===== verif/h_alpha_anisotropy_zone_classifier_core_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// h_alpha_anisotropy_zone_classifier_core_test: zone classifier testbench
// Drives pixels through the stream channel and checks every zone and palette
// color against an in-bench classifier. It covers the threshold edges of
// entropy and alpha, both zone sets, the zone six palette flag and random
// pixels, with random idle bursts on both sides of the block.
// ---------------------------------------------------------------------------
module h_alpha_anisotropy_zone_classifier_core_test;
  import hazc_pkg::*;

  // cycles without any transaction before the run is declared hung
  localparam int unsigned HangLimit = 1000;

  // entropy and alpha edges on the byte codes
  localparam logic [7:0] EntropyHigh = 8'd230;
  localparam logic [7:0] EntropyMid  = 8'd128;
  localparam logic [7:0] AlphaA      = 8'd156;
  localparam logic [7:0] AlphaB      = 8'd142;
  localparam logic [7:0] AlphaC      = 8'd135;
  localparam logic [7:0] AlphaD      = 8'd121;
  localparam logic [7:0] AlphaE      = 8'd114;
  localparam logic [7:0] AnisoHalf   = 8'd128;

  localparam int RedEdges   [5] = '{114, 121, 135, 142, 156};
  localparam int GreenEdges [2] = '{128, 230};

  // zone codes
  localparam logic [3:0] BaseNone     = 4'd8;
  localparam logic [3:0] BaseZoneSix  = 4'd4;
  localparam logic [4:0] Zone16None   = 5'd16;

  // palettes as {red, green, blue}
  localparam logic [23:0] Palette8 [9] = '{
    {8'd176, 8'd203, 8'd10}, {8'd110, 8'd183, 8'd77}, {8'd255, 8'd236, 8'd0},
    {8'd29, 8'd167, 8'd66}, {8'd185, 8'd121, 8'd82}, {8'd230, 8'd52, 8'd19},
    {8'd39, 8'd104, 8'd34}, {8'd13, 8'd82, 8'd160}, {8'd0, 8'd0, 8'd0}
  };
  localparam logic [23:0] Palette16 [17] = '{
    {8'd176, 8'd203, 8'd10}, {8'd136, 8'd169, 8'd24}, {8'd110, 8'd183, 8'd77},
    {8'd98, 8'd196, 8'd220}, {8'd255, 8'd236, 8'd0}, {8'd209, 8'd195, 8'd0},
    {8'd29, 8'd167, 8'd66}, {8'd21, 8'd132, 8'd45}, {8'd186, 8'd121, 8'd82},
    {8'd67, 8'd109, 8'd180}, {8'd230, 8'd52, 8'd19}, {8'd183, 8'd35, 8'd14},
    {8'd39, 8'd104, 8'd34}, {8'd22, 8'd71, 8'd21}, {8'd13, 8'd82, 8'd160},
    {8'd33, 8'd58, 8'd143}, {8'd0, 8'd0, 8'd0}
  };
  localparam logic [23:0] ZoneSixBlue = {8'd67, 8'd109, 8'd180};

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  hazc_in_if  pix_if ();
  hazc_out_if zone_if ();

  // bench copy of the configuration
  logic sixteen_zones;
  logic six_in_blue;

  // randomized idling on each side
  logic src_idle_en;
  logic snk_idle_en;

  result_t     pending_zones [$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  h_alpha_anisotropy_zone_classifier_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (pix_if),
    .out_if     (zone_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // zone and palette color of one pixel
  function automatic result_t classify_pixel(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
    logic [3:0] base;
    result_t    res;
    if (g >= EntropyHigh) begin
      if (r >= AlphaA) base = 4'd0;
      else if (r >= AlphaE) base = 4'd1;
      else base = BaseNone;
    end else if (g >= EntropyMid) begin
      if (r >= AlphaB) base = 4'd2;
      else if (r >= AlphaE) base = 4'd3;
      else base = 4'd4;
    end else begin
      if (r >= AlphaC) base = 4'd5;
      else if (r >= AlphaD) base = 4'd6;
      else base = 4'd7;
    end
    if (sixteen_zones) begin
      if (base == BaseNone) res.zone = Zone16None;
      else res.zone = {base, 1'b0} + ((b >= AnisoHalf) ? 5'd1 : 5'd0);
      res.color = rgb_t'(Palette16[res.zone]);
    end else begin
      res.zone  = {1'b0, base};
      res.color = rgb_t'(Palette8[base]);
      if (base == BaseZoneSix && six_in_blue) res.color = rgb_t'(ZoneSixBlue);
    end
    return res;
  endfunction

  // red code, half of the time close to an alpha edge
  function automatic logic [7:0] pick_red();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
    return 8'(RedEdges[$urandom_range(0, 4)] - 2 + $urandom_range(0, 3));
  endfunction

  // green code, half of the time close to an entropy edge
  function automatic logic [7:0] pick_green();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
    return 8'(GreenEdges[$urandom_range(0, 1)] - 2 + $urandom_range(0, 3));
  endfunction

  // send one pixel and record its expected result on acceptance
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    @(negedge clk_i);
    if (src_idle_en && $urandom_range(0, 7) == 0) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    pix_if.valid    <= 1'b1;
    pix_if.in_red   <= r;
    pix_if.in_green <= g;
    pix_if.in_blue  <= b;
    do @(posedge clk_i); while (!pix_if.ready);
    pending_zones = {pending_zones, classify_pixel(r, g, b)};
  endtask

  // stop sending and let every pending result come out
  task automatic drain_pipeline();
    @(negedge clk_i);
    pix_if.valid <= 1'b0;
    while (pending_zones.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    if (idx == CfgIdxZoneSet) sixteen_zones = val[0];
    else if (idx == CfgIdxUncontrolled) six_in_blue = val[0];
  endtask

  task automatic set_mode(input logic zone_set, input logic six_blue);
    drain_pipeline();
    write_reg(CfgIdxZoneSet, zone_set);
    write_reg(CfgIdxUncontrolled, six_blue);
  endtask

  // entropy and alpha edges in the sixteen-zone set, anisotropy on both sides
  task automatic test_entropy_alpha_edges();
    logic [23:0] edge_pixels [17];
    edge_pixels = '{
      {8'd255, 8'd255, 8'd255}, {8'd156, 8'd230, 8'd0},   {8'd155, 8'd230, 8'd128},
      {8'd114, 8'd230, 8'd127}, {8'd113, 8'd230, 8'd255}, {8'd0, 8'd255, 8'd0},
      {8'd142, 8'd229, 8'd128}, {8'd141, 8'd128, 8'd0},   {8'd114, 8'd128, 8'd200},
      {8'd113, 8'd229, 8'd1},   {8'd0, 8'd128, 8'd128},   {8'd255, 8'd127, 8'd254},
      {8'd135, 8'd0, 8'd127},   {8'd134, 8'd127, 8'd128}, {8'd121, 8'd0, 8'd0},
      {8'd120, 8'd127, 8'd255}, {8'd0, 8'd0, 8'd0}
    };
    set_mode(1'b1, 1'b0);
    foreach (edge_pixels[i])
      send_pixel(edge_pixels[i][23:16], edge_pixels[i][15:8], edge_pixels[i][7:0]);
  endtask

  // zone six in blue, plus a neighbor zone and the unreachable region
  task automatic test_zone_six_color();
    set_mode(1'b0, 1'b1);
    send_pixel(8'd113, 8'd229, 8'd0);
    send_pixel(8'd0, 8'd128, 8'd255);
    send_pixel(8'd134, 8'd127, 8'd0);
    send_pixel(8'd0, 8'd230, 8'd255);
  endtask

  task automatic test_random_pixels(input logic zone_set, input logic six_blue,
                                    input int unsigned count, input logic idle_on);
    set_mode(zone_set, six_blue);
    src_idle_en = idle_on;
    snk_idle_en = idle_on;
    repeat (count) send_pixel(pick_red(), pick_green(), 8'($urandom_range(0, 255)));
  endtask

  // result side: random stall bursts
  initial begin
    zone_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (snk_idle_en && $urandom_range(0, 7) == 0) begin
        zone_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end
      zone_if.ready <= rst_ni;
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni && zone_if.valid && zone_if.ready) begin
      if (pending_zones.size() == 0) begin
        $error("unexpected result: zone %0d", zone_if.zone);
        mismatch_count++;
      end else begin
        exp_res = pending_zones.pop_front();
        if (zone_if.zone !== exp_res.zone) begin
          $error("zone: expected %0d, actual %0d", exp_res.zone, zone_if.zone);
          mismatch_count++;
        end
        if (zone_if.out_red !== exp_res.color.red) begin
          $error("out_red: expected %0d, actual %0d", exp_res.color.red, zone_if.out_red);
          mismatch_count++;
        end
        if (zone_if.out_green !== exp_res.color.green) begin
          $error("out_green: expected %0d, actual %0d", exp_res.color.green,
                 zone_if.out_green);
          mismatch_count++;
        end
        if (zone_if.out_blue !== exp_res.color.blue) begin
          $error("out_blue: expected %0d, actual %0d", exp_res.color.blue, zone_if.out_blue);
          mismatch_count++;
        end
      end
    end
  end

  // hang detection
  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (zone_if.valid && zone_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= HangLimit) begin
        $display("h_alpha_anisotropy_zone_classifier_core_test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;
    pix_if.valid    = 1'b0;
    pix_if.in_red   = 8'd0;
    pix_if.in_green = 8'd0;
    pix_if.in_blue  = 8'd0;
    sixteen_zones   = 1'b0;
    six_in_blue     = 1'b0;
    src_idle_en     = 1'b0;
    snk_idle_en     = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_entropy_alpha_edges();
    test_zone_six_color();
    test_random_pixels(1'b0, 1'b0, 300, 1'b1);
    test_random_pixels(1'b0, 1'b1, 300, 1'b1);
    test_random_pixels(1'b1, 1'b0, 300, 1'b1);
    test_random_pixels(1'b1, 1'b1, 300, 1'b1);
    test_random_pixels(1'b0, 1'b1, 300, 1'b0);
    test_random_pixels(1'b1, 1'b0, 130, 1'b0);
    test_random_pixels(1'b0, 1'b0, 200, 1'b0);
    drain_pipeline();

    if (mismatch_count == 0 && pending_zones.size() == 0) begin
      $display("h_alpha_anisotropy_zone_classifier_core_test passed");
    end else begin
      $display("h_alpha_anisotropy_zone_classifier_core_test failed");
    end
    $finish;
  end

endmodule
